/* src/bspline_keyframe_path_stepper_core_defines.svh */
// Assertion macros for the camera path stepper core.
// Depends on nothing; included by the top level only.
`ifndef BSPLINE_KEYFRAME_PATH_STEPPER_CORE_DEFINES_SVH
`define BSPLINE_KEYFRAME_PATH_STEPPER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BKPS_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BKPS_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/bkps_pkg.sv */
// Shared constants and types of the camera path stepper.
// Depends on nothing; used by the interfaces, the divider, the core and the testbench.
package bkps_pkg;

	localparam int POINT_COUNT = 64;
	localparam int KEY_W       = $clog2(POINT_COUNT);
	localparam int FRAC_BITS   = 16;
	localparam int PROG_W      = FRAC_BITS + 2;
	localparam int UNIT_W      = FRAC_BITS + 1;
	localparam int SPEED_W     = FRAC_BITS + 1;
	localparam int FRAMES_W    = 15;
	localparam int MUL_A_W     = FRAC_BITS + 4;
	localparam int MUL_B_W     = PROG_W + 1;
	localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
	localparam int ACC_W       = MUL_P_W;
	localparam int CX_W        = 28;
	localparam int RECIP3_SH   = 29;
	localparam int POS_SH      = FRAC_BITS - 7;
	localparam int VIEW_SH     = FRAC_BITS + 1;

	localparam logic [PROG_W-1:0]   ONE       = PROG_W'(1 << FRAC_BITS);
	localparam logic [PROG_W-1:0]   PROG_MAX  = PROG_W'((1 << PROG_W) - 1);
	localparam logic [CX_W-1:0]     RECIP3    = CX_W'(178956971);
	localparam logic [ACC_W-1:0]    HALF_POS  = ACC_W'(3 * (1 << (FRAC_BITS - 8)));
	localparam logic [ACC_W-1:0]    HALF_VIEW = ACC_W'(3 * (1 << FRAC_BITS));

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef struct packed {
		logic               op;
		logic [KEY_W-1:0]   point_index;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] point_z;
		logic signed [7:0]  point_roll;
		logic [15:0]        point_view_angle;
		logic [FRAMES_W-1:0] point_frames;
		logic               point_is_end;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] pos_x_out;
		logic signed [23:0] pos_y_out;
		logic signed [23:0] pos_z_out;
		logic signed [15:0] roll_out;
		logic [15:0]        view_angle_out;
		logic               finished;
	} out_item_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} pos_entry_t;

	typedef struct packed {
		logic signed [7:0]   roll;
		logic [15:0]         view;
		logic [FRAMES_W-1:0] frames;
		logic                is_end;
	} attr_entry_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* src/bkps_in_if.sv */
// Input channel of the camera path stepper: valid, ready and one item.
// Depends on bkps_pkg.
interface bkps_in_if import bkps_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/bkps_out_if.sv */
// Result channel of the camera path stepper: valid, ready and one result.
// Depends on bkps_pkg.
interface bkps_out_if import bkps_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/bkps_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module bkps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/bkps_div.sv */
// Serial restoring divider giving the segment speed ONE / frames, one bit a cycle.
// Depends on bkps_pkg.
module bkps_div import bkps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [FRAMES_W-1:0] divisor,
	output div_stat_t           stat,
	output logic [SPEED_W-1:0]  quotient
);

	localparam int STEP_W = $clog2(SPEED_W);

	logic                busy_q, done_q, zero_q;
	logic [STEP_W-1:0]   step_q;
	logic [FRAMES_W-1:0] rem_q, div_q;
	logic [SPEED_W-1:0]  quo_q;
	logic [FRAMES_W:0]   trial, diff;
	logic                ge;

	assign trial = {rem_q, quo_q[SPEED_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(SPEED_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= SPEED_W'(ONE);
			div_q  <= divisor;
			zero_q <= divisor == '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[FRAMES_W-1:0] : trial[FRAMES_W-1:0];
			quo_q <= {quo_q[SPEED_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = zero_q ? '0 : quo_q;

endmodule

/* src/bspline_keyframe_path_stepper_core.sv */
// Camera path stepper: uniform cubic B-spline over a 64-entry keypoint table.
// A load beat is written in the cycle it is accepted. A step beat gives a result, with a
// wrap step when the key advances; an end mark ahead skips the arithmetic. The two serial
// divisions for the segment speeds run one after the other; the coefficient, blend and
// advance products share one multiplier. One beat is in work at a time. Reset clears key
// and progress; the tables keep their contents and read as undefined until loaded.
`include "bspline_keyframe_path_stepper_core_defines.svh"

module bspline_keyframe_path_stepper_core import bkps_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	bkps_in_if.sink item,
	bkps_out_if.source result
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_READ  = 4'd1;
	localparam logic [3:0] ST_CHECK = 4'd2;
	localparam logic [3:0] ST_SPEED = 4'd3;
	localparam logic [3:0] ST_COEF  = 4'd4;
	localparam logic [3:0] ST_MAC   = 4'd5;
	localparam logic [3:0] ST_CONV  = 4'd6;
	localparam logic [3:0] ST_ADV   = 4'd7;
	localparam logic [3:0] ST_WRAP  = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	localparam int SHV_W = MUL_P_W - FRAC_BITS;
	localparam int ADV_W = SHV_W + 1;

	logic [3:0]         state_q;
	logic [4:0]         cnt_q;
	logic [KEY_W-1:0]   key_q;
	logic [PROG_W-1:0]  prog_q;
	logic               out_v_q;
	out_item_t          out_q, res_q;

	pos_entry_t         pos_q [4];
	attr_entry_t        attr_q [4];
	pos_entry_t         pos_wr, pos_rd;
	attr_entry_t        attr_wr, attr_rd;
	logic [KEY_W-1:0]   rd_addr;
	logic               accept, load_we;

	logic               div_start;
	div_stat_t          div_stat;
	logic [SPEED_W-1:0] div_quo, s1_q, s2_q;

	logic [UNIT_W-1:0]  u, w, u2_q, w2_q, u3_q;
	logic signed [MUL_A_W-1:0] u_e, u2_e, u3_e, one_e, k1_c, k2_c;
	logic signed [MUL_A_W-1:0] k_q [4];
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b, mac_val;
	logic signed [MUL_P_W-1:0] prod_s1;
	logic [1:0]         mi_q;
	logic [2:0]         mj_q, mac_j_s1;
	logic               mac_v_s1;
	logic signed [ACC_W-1:0] acc_q [5];

	logic signed [ACC_W-1:0] cacc;
	logic               cneg, cneg_s1, cv_s1;
	logic [ACC_W-1:0]   cmag, cxp, cxv;
	logic [CX_W-1:0]    cx_s1;
	logic [2:0]         cj_s1;
	logic [2*CX_W-1:0]  cprod;
	logic signed [CX_W-1:0] cq;

	logic signed [SPEED_W:0]   sdiff;
	logic signed [SHV_W-1:0]   shv;
	logic signed [ADV_W-1:0]   adv;
	logic [ADV_W-1:0]   newp;
	logic [PROG_W-1:0]  newp_sat;

	function automatic logic [23:0] sat_pos(input logic signed [CX_W-1:0] v);
		if (v > CX_W'(8388607)) begin
			return 24'h7fffff;
		end else if (v < -CX_W'(8388608)) begin
			return 24'h800000;
		end
		return v[23:0];
	endfunction

	function automatic logic [15:0] sat_roll(input logic signed [CX_W-1:0] v);
		if (v > CX_W'(32767)) begin
			return 16'h7fff;
		end else if (v < -CX_W'(32768)) begin
			return 16'h8000;
		end
		return v[15:0];
	endfunction

	function automatic logic [15:0] sat_view(input logic signed [CX_W-1:0] v);
		if (v[CX_W-1]) begin
			return 16'h0000;
		end else if (v > CX_W'(65535)) begin
			return 16'hffff;
		end
		return v[15:0];
	endfunction

	// Table storage and port glue.
	assign accept       = item.valid && item.ready;
	assign load_we      = accept && (item.data.op == OP_LOAD);
	assign item.ready   = state_q == ST_IDLE;
	assign result.valid = out_v_q;
	assign result.data  = out_q;

	assign pos_wr.x       = item.data.point_x;
	assign pos_wr.y       = item.data.point_y;
	assign pos_wr.z       = item.data.point_z;
	assign attr_wr.roll   = item.data.point_roll;
	assign attr_wr.view   = item.data.point_view_angle;
	assign attr_wr.frames = item.data.point_frames;
	assign attr_wr.is_end = item.data.point_is_end;

	always_comb begin
		if (state_q == ST_WRAP) begin
			rd_addr = key_q + KEY_W'(3'd4);
		end else begin
			rd_addr = key_q + KEY_W'(cnt_q[1:0]);
		end
	end

	bkps_ram #(.WIDTH($bits(pos_entry_t)), .DEPTH(POINT_COUNT)) u_pos_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (item.data.point_index),
		.wdata (pos_wr),
		.raddr (rd_addr),
		.rdata (pos_rd)
	);

	bkps_ram #(.WIDTH($bits(attr_entry_t)), .DEPTH(POINT_COUNT)) u_attr_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (item.data.point_index),
		.wdata (attr_wr),
		.raddr (rd_addr),
		.rdata (attr_rd)
	);

	assign div_start = (state_q == ST_SPEED)
		&& ((cnt_q == 5'd0) || ((cnt_q == 5'd1) && div_stat.done));

	bkps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  ((cnt_q == 5'd0) ? attr_q[1].frames : attr_q[2].frames),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// Blending weights.
	assign u     = (prog_q > ONE) ? UNIT_W'(ONE) : UNIT_W'(prog_q);
	assign w     = UNIT_W'(ONE) - u;
	assign u_e   = MUL_A_W'(u);
	assign u2_e  = MUL_A_W'(u2_q);
	assign u3_e  = MUL_A_W'(u3_q);
	assign one_e = MUL_A_W'(ONE);
	assign k1_c  = (u3_e <<< 1) + u3_e - (u2_e <<< 2) - (u2_e <<< 1) + (one_e <<< 2);
	assign k2_c  = (u2_e <<< 1) + u2_e - (u3_e <<< 1) - u3_e + (u_e <<< 1) + u_e + one_e;

	always_comb begin
		case (mj_q)
			3'd0: mac_val = MUL_B_W'(pos_q[mi_q].x);
			3'd1: mac_val = MUL_B_W'(pos_q[mi_q].y);
			3'd2: mac_val = MUL_B_W'(pos_q[mi_q].z);
			3'd3: mac_val = MUL_B_W'(attr_q[mi_q].roll);
			3'd4: mac_val = MUL_B_W'(attr_q[mi_q].view);
			default: mac_val = '0;
		endcase
	end

	assign sdiff = $signed({1'b0, s2_q}) - $signed({1'b0, s1_q});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_COEF: begin
				case (cnt_q)
					5'd0: begin mul_a = MUL_A_W'(u);    mul_b = MUL_B_W'(u); end
					5'd1: begin mul_a = MUL_A_W'(w);    mul_b = MUL_B_W'(w); end
					5'd2: begin mul_a = MUL_A_W'(u2_q); mul_b = MUL_B_W'(u); end
					5'd3: begin mul_a = MUL_A_W'(w2_q); mul_b = MUL_B_W'(w); end
					default: ;
				endcase
			end
			ST_MAC: begin
				mul_a = k_q[mi_q];
				mul_b = mac_val;
			end
			ST_ADV: begin
				mul_a = MUL_A_W'(sdiff);
				mul_b = MUL_B_W'(prog_q);
			end
			default: ;
		endcase
	end

	// Output scaling: rounded magnitude divided by three through a reciprocal.
	assign cacc  = acc_q[cnt_q[2:0]];
	assign cneg  = cacc[ACC_W-1];
	assign cmag  = cneg ? ACC_W'(-cacc) : ACC_W'(cacc);
	assign cxp   = (cmag + HALF_POS) >> POS_SH;
	assign cxv   = (cmag + HALF_VIEW) >> VIEW_SH;
	assign cprod = cx_s1 * RECIP3;
	assign cq    = cneg_s1 ? -CX_W'(cprod[RECIP3_SH +: CX_W-1])
		: CX_W'(cprod[RECIP3_SH +: CX_W-1]);

	// Progress update.
	assign shv      = $signed(prod_s1[MUL_P_W-1:FRAC_BITS]);
	assign adv      = ADV_W'(shv) + $signed(ADV_W'(s1_q));
	assign newp     = ADV_W'(prog_q) + (adv[ADV_W-1] ? '0 : adv);
	assign newp_sat = (newp > ADV_W'(PROG_MAX)) ? PROG_MAX : newp[PROG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			key_q    <= '0;
			prog_q   <= '0;
			out_v_q  <= 1'b0;
			mac_v_s1 <= 1'b0;
			cv_s1    <= 1'b0;
			mi_q     <= '0;
			mj_q     <= '0;
		end else begin
			mac_v_s1 <= (state_q == ST_MAC) && (cnt_q < 5'd20);
			cv_s1    <= (state_q == ST_CONV) && (cnt_q < 5'd5);
			if ((state_q == ST_DONE) && (!out_v_q || result.ready)) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept && (item.data.op == OP_STEP)) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (cnt_q == 5'd4) begin
						cnt_q   <= '0;
						state_q <= ST_CHECK;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_CHECK: begin
					if (attr_q[0].is_end || attr_q[1].is_end || attr_q[2].is_end) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SPEED;
					end
				end
				ST_SPEED: begin
					if (cnt_q == 5'd0) begin
						cnt_q <= 5'd1;
					end else if (div_stat.done) begin
						if (cnt_q == 5'd2) begin
							cnt_q   <= '0;
							state_q <= ST_COEF;
						end else begin
							cnt_q <= cnt_q + 5'd1;
						end
					end
				end
				ST_COEF: begin
					if (cnt_q == 5'd4) begin
						cnt_q   <= '0;
						mi_q    <= '0;
						mj_q    <= '0;
						state_q <= ST_MAC;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_MAC: begin
					if (mj_q == 3'd4) begin
						mj_q <= '0;
						mi_q <= mi_q + 2'd1;
					end else begin
						mj_q <= mj_q + 3'd1;
					end
					if (cnt_q == 5'd20) begin
						cnt_q   <= '0;
						state_q <= ST_CONV;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_CONV: begin
					if (cnt_q == 5'd5) begin
						cnt_q   <= '0;
						state_q <= ST_ADV;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_ADV: begin
					if (cnt_q == 5'd1) begin
						cnt_q <= '0;
						if (newp_sat >= ONE) begin
							prog_q  <= newp_sat - ONE;
							state_q <= ST_WRAP;
						end else begin
							prog_q  <= newp_sat;
							state_q <= ST_DONE;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_WRAP: begin
					if (cnt_q == 5'd1) begin
						cnt_q   <= '0;
						key_q   <= attr_rd.is_end ? '0 : key_q + KEY_W'(1);
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_DONE: begin
					if (!out_v_q || result.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= mul_a * mul_b;
		mac_j_s1 <= mj_q;
		cx_s1    <= (cnt_q == 5'd4) ? CX_W'(cxv) : CX_W'(cxp);
		cneg_s1  <= cneg;
		cj_s1    <= cnt_q[2:0];

		if ((state_q == ST_READ) && (cnt_q != 5'd0)) begin
			pos_q[0]  <= pos_q[1];
			pos_q[1]  <= pos_q[2];
			pos_q[2]  <= pos_q[3];
			pos_q[3]  <= pos_rd;
			attr_q[0] <= attr_q[1];
			attr_q[1] <= attr_q[2];
			attr_q[2] <= attr_q[3];
			attr_q[3] <= attr_rd;
		end

		if (state_q == ST_CHECK) begin
			res_q <= '{finished: 1'b1, default: '0};
			for (int j = 0; j < 5; j++) begin
				acc_q[j] <= '0;
			end
		end

		if ((state_q == ST_SPEED) && div_stat.done) begin
			if (cnt_q == 5'd1) begin
				s1_q <= div_quo;
			end else begin
				s2_q <= div_quo;
			end
		end

		if (state_q == ST_COEF) begin
			case (cnt_q)
				5'd1: u2_q <= prod_s1[FRAC_BITS +: UNIT_W];
				5'd2: w2_q <= prod_s1[FRAC_BITS +: UNIT_W];
				5'd3: u3_q <= prod_s1[FRAC_BITS +: UNIT_W];
				5'd4: begin
					k_q[0] <= MUL_A_W'(prod_s1[FRAC_BITS +: UNIT_W]);
					k_q[1] <= k1_c;
					k_q[2] <= k2_c;
					k_q[3] <= u3_e;
				end
				default: ;
			endcase
		end

		if (mac_v_s1) begin
			acc_q[mac_j_s1] <= acc_q[mac_j_s1] + ACC_W'(prod_s1);
		end

		if (cv_s1) begin
			case (cj_s1)
				3'd0: res_q.pos_x_out      <= sat_pos(cq);
				3'd1: res_q.pos_y_out      <= sat_pos(cq);
				3'd2: res_q.pos_z_out      <= sat_pos(cq);
				3'd3: res_q.roll_out       <= sat_roll(cq);
				3'd4: res_q.view_angle_out <= sat_view(cq);
				default: ;
			endcase
		end

		if ((state_q == ST_ADV) && (cnt_q == 5'd1)) begin
			res_q.finished <= 1'b0;
		end

		if ((state_q == ST_WRAP) && (cnt_q == 5'd1)) begin
			res_q.finished <= attr_rd.is_end;
		end

		if ((state_q == ST_DONE) && (!out_v_q || result.ready)) begin
			out_q <= res_q;
		end
	end

	`BKPS_ASSERT_NXT(a_key_only_on_wrap, clk, arst_n, state_q != ST_WRAP, $stable(key_q), "key changed outside the wrap step")
	`BKPS_ASSERT_IMP(a_div_start_idle, clk, arst_n, div_start, !div_stat.busy, "divider started while busy")
	`BKPS_ASSERT_IMP(a_result_from_done, clk, arst_n, $rose(out_v_q), $past(state_q) == ST_DONE, "result beat raised outside the done state")

endmodule

/* sim/bspline_keyframe_path_stepper_core_tb.sv */
// Testbench for the camera path stepper: loads keypoints and steps the path under random
// idling and stalls, checking every result against an independent fixed-point model.
// Depends on bkps_pkg, bkps_in_if, bkps_out_if and the core itself.
module bspline_keyframe_path_stepper_core_tb;
	import bkps_pkg::*;

	class camera_path_scoreboard;
		pos_entry_t  positions[POINT_COUNT];
		attr_entry_t attributes[POINT_COUNT];
		logic [KEY_W-1:0] key;
		longint      progress;
		out_item_t   expected_frames[$];
		int          errors;
		int          steps;
		int          finishes;

		function new();
			key = '0;
			progress = 0;
			errors = 0;
			steps = 0;
			finishes = 0;
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function longint round_div(longint num, longint den);
			if (num >= 0) begin
				return (num + den / 2) / den;
			end
			return -((-num + den / 2) / den);
		endfunction

		function longint speed(logic [KEY_W-1:0] k);
			longint f;
			f = longint'(attributes[k].frames);
			return f == 0 ? 0 : 65536 / f;
		endfunction

		function void note_beat(in_item_t it);
			longint one, u, w, u2, u3, w2, w3, s1, s2, prod, adv;
			longint c[4];
			longint acc[5];
			logic [KEY_W-1:0] k;
			out_item_t r;
			one = longint'(1) << FRAC_BITS;
			if (it.op == OP_LOAD) begin
				positions[it.point_index] = '{it.point_x, it.point_y, it.point_z};
				attributes[it.point_index] = '{it.point_roll, it.point_view_angle,
					it.point_frames, it.point_is_end};
				return;
			end
			r = '0;
			steps++;
			if (attributes[key].is_end || attributes[KEY_W'(key + 1)].is_end ||
					attributes[KEY_W'(key + 2)].is_end) begin
				r.finished = 1'b1;
				finishes++;
				expected_frames.push_back(r);
				return;
			end
			u = progress > one ? one : progress;
			w = one - u;
			u2 = (u * u) >>> FRAC_BITS;
			u3 = (u2 * u) >>> FRAC_BITS;
			w2 = (w * w) >>> FRAC_BITS;
			w3 = (w2 * w) >>> FRAC_BITS;
			c[0] = w3;
			c[1] = 3 * u3 - 6 * u2 + 4 * one;
			c[2] = -3 * u3 + 3 * u2 + 3 * u + one;
			c[3] = u3;
			foreach (acc[j]) acc[j] = 0;
			for (int i = 0; i < 4; i++) begin
				k = KEY_W'(key + i);
				acc[0] += c[i] * longint'(positions[k].x);
				acc[1] += c[i] * longint'(positions[k].y);
				acc[2] += c[i] * longint'(positions[k].z);
				acc[3] += c[i] * longint'(attributes[k].roll);
				acc[4] += c[i] * longint'(attributes[k].view);
			end
			r.pos_x_out = 24'(clamp(round_div(acc[0] * 256, 6 * one), -8388608, 8388607));
			r.pos_y_out = 24'(clamp(round_div(acc[1] * 256, 6 * one), -8388608, 8388607));
			r.pos_z_out = 24'(clamp(round_div(acc[2] * 256, 6 * one), -8388608, 8388607));
			r.roll_out = 16'(clamp(round_div(acc[3] * 256, 6 * one), -32768, 32767));
			r.view_angle_out = 16'(clamp(round_div(acc[4], 6 * one), 0, 65535));
			s1 = speed(KEY_W'(key + 1));
			s2 = speed(KEY_W'(key + 2));
			prod = (progress * (s2 - s1)) >>> FRAC_BITS;
			adv = prod + s1;
			if (adv < 0) begin
				adv = 0;
			end
			progress = clamp(progress + adv, 0, (longint'(1) << PROG_W) - 1);
			if (progress >= one) begin
				key = KEY_W'(key + 1);
				if (attributes[KEY_W'(key + 3)].is_end) begin
					key = '0;
					r.finished = 1'b1;
					finishes++;
				end
				progress -= one;
			end
			expected_frames.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (expected_frames.size() == 0) begin
				$error("result beat with no step waiting for it");
				errors++;
				return;
			end
			e = expected_frames.pop_front();
			if (got.pos_x_out !== e.pos_x_out) begin
				$error("pos_x_out: expected %0d, got %0d", e.pos_x_out, got.pos_x_out);
				errors++;
			end
			if (got.pos_y_out !== e.pos_y_out) begin
				$error("pos_y_out: expected %0d, got %0d", e.pos_y_out, got.pos_y_out);
				errors++;
			end
			if (got.pos_z_out !== e.pos_z_out) begin
				$error("pos_z_out: expected %0d, got %0d", e.pos_z_out, got.pos_z_out);
				errors++;
			end
			if (got.roll_out !== e.roll_out) begin
				$error("roll_out: expected %0d, got %0d", e.roll_out, got.roll_out);
				errors++;
			end
			if (got.view_angle_out !== e.view_angle_out) begin
				$error("view_angle_out: expected %0d, got %0d", e.view_angle_out,
					got.view_angle_out);
				errors++;
			end
			if (got.finished !== e.finished) begin
				$error("finished: expected %0b, got %0b", e.finished, got.finished);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bkps_in_if  item();
	bkps_out_if result();

	bspline_keyframe_path_stepper_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.result(result)
	);

	camera_path_scoreboard board = new();
	int  hold_requests = 0;
	int  holds_seen = 0;
	int  hold_left = 0;
	int  ready_gap = 0;
	bit  quiet = 0;
	int  beats = 0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else if (holds_seen != hold_requests) begin
			holds_seen <= hold_requests;
			hold_left <= 400;
			result.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result.ready <= 1'b0;
		end else if (ready_gap > 0) begin
			ready_gap <= ready_gap - 1;
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
			if (!quiet && $urandom_range(0, 3) == 0) begin
				ready_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 3);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			board.check_result(result.data);
		end
	end

	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'hffff;
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_item_t keypoint(logic [KEY_W-1:0] slot_no, bit allow_end);
		in_item_t p;
		p.op = OP_LOAD;
		p.point_index = slot_no;
		p.point_x = pick16();
		p.point_y = pick16();
		p.point_z = pick16();
		p.point_roll = 8'(pick16());
		p.point_view_angle = pick16();
		case ($urandom_range(0, 9))
			0: p.point_frames = '0;
			1: p.point_frames = FRAMES_W'($urandom);
			2: p.point_frames = {FRAMES_W{1'b1}};
			3: p.point_frames = FRAMES_W'($urandom_range(5, 100));
			default: p.point_frames = FRAMES_W'($urandom_range(1, 4));
		endcase
		p.point_is_end = allow_end && ($urandom_range(0, 15) == 0);
		return p;
	endfunction

	function automatic in_item_t step_beat();
		in_item_t p;
		p = in_item_t'({$urandom, $urandom, $urandom, $urandom});
		p.op = OP_STEP;
		return p;
	endfunction

	task automatic send(in_item_t p);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 2) == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
		end
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.data <= p;
		do @(posedge clk); while (!item.ready);
		board.note_beat(p);
		beats++;
	endtask

	task automatic drain();
		item.valid <= 1'b0;
		while (board.expected_frames.size() != 0) @(posedge clk);
	endtask

	initial begin
		in_item_t p;
		arst_n = 1'b0;
		item.valid = 1'b0;
		item.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < POINT_COUNT; i++) begin
			send(keypoint(KEY_W'(i), 1'b0));
		end
		// Extreme keypoints at the start of the path, then a few steps across them.
		for (int i = 0; i < 6; i++) begin
			p = keypoint(KEY_W'(i), 1'b0);
			p.point_x = (i % 2) ? 16'sh7fff : 16'sh8000;
			p.point_y = 16'sh7fff;
			p.point_z = 16'sh8000;
			p.point_roll = (i % 2) ? 8'sh7f : 8'sh80;
			p.point_view_angle = (i % 2) ? 16'hffff : 16'h0000;
			p.point_frames = (i == 2) ? '0 : ((i == 3) ? {FRAMES_W{1'b1}} : FRAMES_W'(1));
			send(p);
		end
		repeat (6) send(step_beat());
		// An end mark ahead of the key, then the mark cleared again and one more step.
		p = keypoint(KEY_W'(2), 1'b0);
		p.point_is_end = 1'b1;
		send(p);
		send(step_beat());
		send(keypoint(KEY_W'(2), 1'b0));
		send(step_beat());
		drain();

		for (int n = 0; n < 900; n++) begin
			if (n % 100 == 0) begin
				quiet = ($urandom_range(0, 3) == 0);
			end
			if (n == 300) begin
				hold_requests++;
			end
			if (n == 600) begin
				drain();
			end
			if ($urandom_range(0, 1) == 0) begin
				send(keypoint(KEY_W'($urandom), 1'b1));
			end else begin
				send(step_beat());
			end
		end
		drain();
		repeat (100) @(posedge clk);

		$display("Ran %0d input beats, %0d steps of which %0d reported finished.",
			beats, board.steps, board.finishes);
		if (board.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#50000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/bkps_pkg.sv
src/bkps_in_if.sv
src/bkps_out_if.sv
src/bkps_ram.sv
src/bkps_div.sv
src/bspline_keyframe_path_stepper_core.sv
sim/bspline_keyframe_path_stepper_core_tb.sv
